// File: hdl/first_fit_block_allocator_defines.svh
// assertion macros for the first-fit block allocator checker
// relies on clk_i and rst_ni being visible where a macro is used
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define FFBA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define FFBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/ffba_pkg.sv
// shared types and constants of the first-fit block allocator
// no dependencies
package ffba_pkg;

  localparam int OWNER_W    = 16;
  localparam int SIZE_W     = 22;
  localparam int BSIZE_W    = 16;
  localparam int BCOUNT_W   = 7;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;
  localparam int START_W    = 6;
  localparam int TOTAL_W    = 7;
  // byte accumulator of a free run: below request size plus one block size
  localparam int ACC_W      = SIZE_W + 1;

  localparam logic [BSIZE_W-1:0]  BSIZE_RST  = 16'd20;
  localparam logic [BCOUNT_W-1:0] BCOUNT_RST = 7'd5;

  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 8'd1;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_NO_SPACE    = 2'd1,
    ST_NOT_FOUND   = 2'd2,
    ST_BAD_REQUEST = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ASCAN,
    S_AMARK,
    S_FFIND,
    S_FREL,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic    load;
    logic    a_step;
    logic    a_hit;
    logic    mark;
    logic    f_step;
    logic    f_hit;
    logic    release_blk;
    logic    set_res;
    status_e res_code;
    logic    out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic bad_req;
    logic at_end;
    logic used_cur;
    logic owner_hit;
    logic fit;
    logic mark_last;
    logic out_busy;
  } dp_status_t;

endpackage

// File: hdl/ffba_if.sv
// valid/ready channels of the first-fit block allocator
// depends on ffba_pkg
interface ffba_req_if;
  import ffba_pkg::*;
  logic                 valid;
  logic                 ready;
  op_e                  op;
  logic [OWNER_W-1:0]   owner_id;
  logic [SIZE_W-1:0]    request_size;
  modport source (output valid, op, owner_id, request_size, input ready);
  modport sink   (input valid, op, owner_id, request_size, output ready);
endinterface

interface ffba_rsp_if;
  import ffba_pkg::*;
  logic               valid;
  logic               ready;
  status_e            status;
  logic [START_W-1:0] start_block;
  logic [TOTAL_W-1:0] block_total;
  modport source (output valid, status, start_block, block_total, input ready);
  modport sink   (input valid, status, start_block, block_total, output ready);
endinterface

interface ffba_cfg_if;
  import ffba_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: hdl/ffba_controller.sv
// sequencing state machine of the first-fit block allocator
// depends on ffba_pkg, drives ffba_datapath through ctrl_cmd_t
module ffba_controller (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  ffba_pkg::op_e         in_op_i,
  output logic                  in_ready_o,
  input  ffba_pkg::dp_status_t  stat_i,
  output ffba_pkg::ctrl_cmd_t   cmd_o
);
  import ffba_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = (in_op_i == OP_ALLOC) ? S_ASCAN : S_FFIND;
        end
      end
      S_ASCAN: begin
        if (stat_i.bad_req || stat_i.at_end) begin
          state_d = S_FINISH;
        end else if (!stat_i.used_cur && stat_i.fit) begin
          state_d = S_AMARK;
        end
      end
      S_AMARK: begin
        if (stat_i.mark_last) begin
          state_d = S_FINISH;
        end
      end
      S_FFIND: begin
        if (stat_i.at_end) begin
          state_d = S_FINISH;
        end else if (stat_i.used_cur && stat_i.owner_hit) begin
          state_d = S_FREL;
        end
      end
      S_FREL: begin
        if (stat_i.at_end || !stat_i.used_cur || !stat_i.owner_hit) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!stat_i.out_busy) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.res_code = ST_OK;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      S_ASCAN: begin
        if (stat_i.bad_req) begin
          cmd_o.set_res  = 1'b1;
          cmd_o.res_code = ST_BAD_REQUEST;
        end else if (stat_i.at_end) begin
          cmd_o.set_res  = 1'b1;
          cmd_o.res_code = ST_NO_SPACE;
        end else if (!stat_i.used_cur && stat_i.fit) begin
          cmd_o.a_hit = 1'b1;
        end else begin
          cmd_o.a_step = 1'b1;
        end
      end
      S_AMARK: begin
        cmd_o.mark = 1'b1;
        if (stat_i.mark_last) begin
          cmd_o.set_res = 1'b1;
        end
      end
      S_FFIND: begin
        if (stat_i.at_end) begin
          cmd_o.set_res  = 1'b1;
          cmd_o.res_code = ST_NOT_FOUND;
        end else if (stat_i.used_cur && stat_i.owner_hit) begin
          cmd_o.f_hit = 1'b1;
        end else begin
          cmd_o.f_step = 1'b1;
        end
      end
      S_FREL: begin
        if (!stat_i.at_end && stat_i.used_cur && stat_i.owner_hit) begin
          cmd_o.release_blk = 1'b1;
        end else begin
          cmd_o.set_res = 1'b1;
        end
      end
      S_FINISH: begin
        cmd_o.out_load = !stat_i.out_busy;
      end
      default: ;
    endcase
  end

endmodule

// File: hdl/ffba_datapath.sv
// block map, owner table, scan counters and result register
// depends on ffba_pkg, commanded by ffba_controller
module ffba_datapath #(
  parameter int MAX_BLOCKS = 64,
  parameter int OWNER_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  ffba_pkg::ctrl_cmd_t             cmd_i,
  output ffba_pkg::dp_status_t            stat_o,
  input  logic [ffba_pkg::OWNER_W-1:0]    in_owner_i,
  input  logic [ffba_pkg::SIZE_W-1:0]     in_size_i,
  input  logic                            cfg_we_i,
  input  logic [ffba_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ffba_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output ffba_pkg::status_e               out_status_o,
  output logic [ffba_pkg::START_W-1:0]    out_start_o,
  output logic [ffba_pkg::TOTAL_W-1:0]    out_total_o
);
  import ffba_pkg::*;

  localparam int IdxW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CntW = $clog2(MAX_BLOCKS + 1);
  localparam int CmpW = (CntW > BCOUNT_W) ? CntW : BCOUNT_W;
  localparam logic [CntW-1:0] One = CntW'(1);

  logic [BSIZE_W-1:0]  bsize_q;
  logic [BCOUNT_W-1:0] bcount_q;
  logic [CntW-1:0]     live_n;

  logic [OWNER_BITS-1:0] who_q;
  logic [SIZE_W-1:0]     bytes_q;
  logic [CntW-1:0]       ptr_q, ptr_d;
  logic [CntW-1:0]       run_q, run_d;
  logic [ACC_W-1:0]      acc_q, acc_d, acc_n;
  logic [IdxW-1:0]       start_q, start_d;
  logic [CntW-1:0]       total_q, total_d;
  status_e               res_q, res_d;
  logic [IdxW-1:0]       idx;

  logic [MAX_BLOCKS-1:0] used_q;
  logic [OWNER_BITS-1:0] owner_mem [MAX_BLOCKS];
  logic [OWNER_BITS-1:0] rd_q;

  logic                  out_valid_q;
  status_e               out_status_q;
  logic [IdxW-1:0]       out_start_q;
  logic [CntW-1:0]       out_total_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bsize_q  <= BSIZE_RST;
      bcount_q <= BCOUNT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_BLOCK_SIZE:  bsize_q  <= BSIZE_W'(cfg_data_i);
        REG_BLOCK_COUNT: bcount_q <= BCOUNT_W'(cfg_data_i);
        default: ;
      endcase
    end
  end

  // block count saturates at the built depth
  always_comb begin
    if (CmpW'(bcount_q) > CmpW'(MAX_BLOCKS)) begin
      live_n = CntW'(MAX_BLOCKS);
    end else begin
      live_n = CntW'(bcount_q);
    end
  end

  assign idx   = ptr_q[IdxW-1:0];
  assign acc_n = acc_q + ACC_W'(bsize_q);

  assign stat_o.bad_req   = (bytes_q == '0) || (bsize_q == '0);
  assign stat_o.at_end    = (ptr_q >= live_n);
  assign stat_o.used_cur  = used_q[idx];
  assign stat_o.owner_hit = (rd_q == who_q);
  // run reaches the block count of the request exactly when its bytes cover it
  assign stat_o.fit       = (acc_n >= ACC_W'(bytes_q));
  assign stat_o.mark_last = (run_q == One);
  assign stat_o.out_busy  = out_valid_q && !out_ready_i;

  always_comb begin
    ptr_d   = ptr_q;
    run_d   = run_q;
    acc_d   = acc_q;
    start_d = start_q;
    total_d = total_q;
    res_d   = res_q;
    if (cmd_i.load) begin
      ptr_d = '0;
      run_d = '0;
      acc_d = '0;
    end
    if (cmd_i.a_step) begin
      ptr_d = ptr_q + One;
      if (used_q[idx]) begin
        run_d = '0;
        acc_d = '0;
      end else begin
        run_d = run_q + One;
        acc_d = acc_n;
      end
    end
    if (cmd_i.a_hit) begin
      // run restarts as the count of blocks left to mark
      start_d = IdxW'(ptr_q - run_q);
      total_d = run_q + One;
      ptr_d   = ptr_q - run_q;
      run_d   = run_q + One;
    end
    if (cmd_i.mark) begin
      ptr_d = ptr_q + One;
      run_d = run_q - One;
    end
    if (cmd_i.f_step || cmd_i.release_blk) begin
      ptr_d = ptr_q + One;
    end
    if (cmd_i.f_hit) begin
      start_d = idx;
      total_d = '0;
    end
    if (cmd_i.release_blk) begin
      total_d = total_q + One;
    end
    if (cmd_i.set_res) begin
      res_d = cmd_i.res_code;
      if (cmd_i.res_code != ST_OK) begin
        start_d = '0;
        total_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q   <= ptr_d;
    run_q   <= run_d;
    acc_q   <= acc_d;
    start_q <= start_d;
    total_q <= total_d;
    res_q   <= res_d;
    if (cmd_i.load) begin
      who_q   <= OWNER_BITS'(in_owner_i);
      bytes_q <= in_size_i;
    end
  end

  // used bits double as the valid bits of the owner table
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else if (cmd_i.mark) begin
      used_q[idx] <= 1'b1;
    end else if (cmd_i.release_blk) begin
      used_q[idx] <= 1'b0;
    end
  end

  // owner table, read always follows the next pointer so rd_q matches ptr_q
  always_ff @(posedge clk_i) begin
    if (cmd_i.mark) begin
      owner_mem[idx] <= who_q;
    end
    rd_q <= owner_mem[ptr_d[IdxW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_status_q <= res_q;
      out_start_q  <= start_q;
      out_total_q  <= total_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_start_o  = START_W'(out_start_q);
  assign out_total_o  = TOTAL_W'(out_total_q);

endmodule

// File: hdl/first_fit_block_allocator.sv
// First-fit contiguous block allocator. Each request word (allocate or free)
// gives exactly one result word. A request walks the block map one entry per
// cycle through the owner table. An allocate is accepted, scans until a free
// run that fits ends (to the end of the map on a miss, stopping at once on a
// bad request), marks the run block by block, then posts the result. A free
// is accepted, scans to the owner's first block (to the end of the map when
// the owner holds none), releases the owner's contiguous blocks from there,
// then posts the result. Posting waits while the output register still holds
// an untaken result word. One request is in work at a time; a finished result
// waits in an output register while the next request is taken. Used bits
// clear at reset at once, so no clearing pass is needed. block_size and
// block_count must be written through the configuration channel only while
// no request is in work; the block itself does not enforce this.
// depends on ffba_pkg, ffba_if, ffba_controller and ffba_datapath
module first_fit_block_allocator #(
  parameter int MAX_BLOCKS = 64,
  parameter int OWNER_BITS = 16
) (
  input logic      clk_i,
  input logic      rst_ni,
  ffba_req_if.sink   req_i,
  ffba_rsp_if.source rsp_o,
  ffba_cfg_if.sink   cfg_i
);
  import ffba_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t stat;

  assign cfg_i.ready = 1'b1;

  ffba_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_op_i    (req_i.op),
    .in_ready_o (req_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ffba_datapath #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .OWNER_BITS (OWNER_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .in_owner_i   (req_i.owner_id),
    .in_size_i    (req_i.request_size),
    .cfg_we_i     (cfg_i.valid),
    .cfg_idx_i    (cfg_i.index),
    .cfg_data_i   (cfg_i.data),
    .out_valid_o  (rsp_o.valid),
    .out_ready_i  (rsp_o.ready),
    .out_status_o (rsp_o.status),
    .out_start_o  (rsp_o.start_block),
    .out_total_o  (rsp_o.block_total)
  );

endmodule

// File: hdl/ffba_checker.sv
// port-level checks of the first-fit block allocator, bound to the top level
// depends on ffba_pkg and first_fit_block_allocator_defines.svh
`include "first_fit_block_allocator_defines.svh"

module ffba_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         req_valid_i,
  input logic                         req_ready_i,
  input logic                         rsp_valid_i,
  input logic                         rsp_ready_i,
  input ffba_pkg::status_e            rsp_status_i,
  input logic [ffba_pkg::START_W-1:0] rsp_start_i,
  input logic [ffba_pkg::TOTAL_W-1:0] rsp_total_i
);
  import ffba_pkg::*;

  // a waiting result word holds until taken
  `FFBA_ASSERT_NEXT(a_rsp_hold, rsp_valid_i && !rsp_ready_i, rsp_valid_i && $stable(rsp_status_i) && $stable(rsp_start_i) && $stable(rsp_total_i), "result changed while stalled")

  // failed requests report no blocks
  `FFBA_ASSERT_IMPL(a_fail_zero, rsp_valid_i && (rsp_status_i != ST_OK), (rsp_start_i == '0) && (rsp_total_i == '0), "failed result with nonzero blocks")

  // a successful request always moves at least one block
  `FFBA_ASSERT_IMPL(a_ok_nonzero, rsp_valid_i && (rsp_status_i == ST_OK), rsp_total_i != '0, "ok result with zero blocks")

  // one request at a time: busy right after an accept
  `FFBA_ASSERT_NEXT(a_busy_after_accept, req_valid_i && req_ready_i, !req_ready_i, "request taken while previous in work")

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_status_i (rsp_o.status),
  .rsp_start_i  (rsp_o.start_block),
  .rsp_total_i  (rsp_o.block_total)
);
